### hw/rtl/gdn_pkg.sv
`default_nettype none

package gdn_pkg;

	// Operation codes carried in the request
	localparam logic [1:0] OpToSerial = 2'd0;
	localparam logic [1:0] OpToDate   = 2'd1;
	localparam logic [1:0] OpDiff     = 2'd2;

	// Calendar constants
	localparam int DaysPerYear  = 365;
	localparam int DaysLeapYear = 366;
	localparam int Centennial   = 100;

	// Floor division by 25 as (x * Recip25) >> RecipShift, exact for x below 43690
	localparam int RecipW     = 16;
	localparam int Recip25    = 41944;
	localparam int RecipShift = 20;

	// Year estimate from a day number: (n * EstMul) >> EstShift, about n / 365.2425
	localparam int EstW     = 16;
	localparam int EstMul   = 45935;
	localparam int EstShift = 24;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [13:0] year_a;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [13:0] year_b;
		logic [21:0] serial_in;
	} req_t;

	typedef struct packed {
		logic signed [22:0] serial_out;
		logic [4:0]         day_out;
		logic [3:0]         month_out;
		logic [13:0]        year_out;
		logic               bad_input;
	} rsp_t;

	// Microcode
	localparam int StepW = 6;
	typedef logic [StepW-1:0] step_t;

	typedef enum logic [2:0] {
		YR_HOLD     = 3'd0,
		YR_LOAD_A   = 3'd1,
		YR_LOAD_B   = 3'd2,
		YR_LOAD_EST = 3'd3,
		YR_SEARCH   = 3'd4
	} yr_src_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_SUB  = 2'd2
	} acc_op_t;

	typedef enum logic [2:0] {
		COND_NEXT   = 3'd0,
		COND_ALWAYS = 3'd1,
		COND_BAD    = 3'd2,
		COND_OP1    = 3'd3,
		COND_OP2    = 3'd4,
		COND_MOVE   = 3'd5
	} cond_t;

	typedef struct packed {
		yr_src_t yr_src;
		logic    plus1;
		logic    cap_lo;
		logic    cap_hi;
		logic    num_en;
		logic    use_b;
		acc_op_t acc_op;
		logic    rem_en;
		logic    mon_en;
		logic    day_en;
		logic    done;
		cond_t   cond;
		step_t   target;
	} ctrl_t;

	typedef struct packed {
		logic bad;
		logic op1;
		logic op2;
		logic move;
	} stat_t;

	// Program entry points
	localparam step_t StepB0   = step_t'(10);
	localparam step_t StepA2   = step_t'(17);
	localparam step_t StepY0   = step_t'(24);
	localparam step_t StepLoop = step_t'(25);
	localparam step_t StepDone = step_t'(33);

	// Control store
	function automatic ctrl_t rom_word(step_t s);
		ctrl_t w;
		w = '0;
		case (s)
			// dispatch
			step_t'(0): begin w.cond = COND_BAD; w.target = StepDone; end
			step_t'(1): begin w.cond = COND_OP1; w.target = StepY0; end
			step_t'(2): begin w.cond = COND_OP2; w.target = StepB0; end
			// date A to number
			step_t'(3): w.yr_src = YR_LOAD_A;
			step_t'(4): w.plus1 = 1'b0;
			step_t'(5): w.plus1 = 1'b1;
			step_t'(6): w.cap_lo = 1'b1;
			step_t'(7): w.cap_hi = 1'b1;
			step_t'(8): w.num_en = 1'b1;
			step_t'(9): begin
				w.acc_op = ACC_LOAD; w.cond = COND_ALWAYS; w.target = StepDone;
			end
			// difference: date B first
			step_t'(10): w.yr_src = YR_LOAD_B;
			step_t'(11): w.plus1 = 1'b0;
			step_t'(12): w.plus1 = 1'b1;
			step_t'(13): w.cap_lo = 1'b1;
			step_t'(14): w.cap_hi = 1'b1;
			step_t'(15): begin w.num_en = 1'b1; w.use_b = 1'b1; end
			step_t'(16): w.acc_op = ACC_LOAD;
			// then subtract date A
			step_t'(17): w.yr_src = YR_LOAD_A;
			step_t'(18): w.plus1 = 1'b0;
			step_t'(19): w.plus1 = 1'b1;
			step_t'(20): w.cap_lo = 1'b1;
			step_t'(21): w.cap_hi = 1'b1;
			step_t'(22): w.num_en = 1'b1;
			step_t'(23): begin
				w.acc_op = ACC_SUB; w.cond = COND_ALWAYS; w.target = StepDone;
			end
			// number to date: estimate, then walk the year
			step_t'(24): w.yr_src = YR_LOAD_EST;
			step_t'(25): w.plus1 = 1'b0;
			step_t'(26): w.plus1 = 1'b1;
			step_t'(27): w.cap_lo = 1'b1;
			step_t'(28): w.cap_hi = 1'b1;
			step_t'(29): begin
				w.yr_src = YR_SEARCH; w.cond = COND_MOVE; w.target = StepLoop;
			end
			step_t'(30): w.rem_en = 1'b1;
			step_t'(31): w.mon_en = 1'b1;
			step_t'(32): w.day_en = 1'b1;
			step_t'(33): w.done = 1'b1;
			default: w.done = 1'b1;
		endcase
		return w;
	endfunction

	// Days in the months before month m
	function automatic logic [8:0] cum_days(logic [3:0] m, logic leap);
		logic [8:0] c;
		case (m)
			4'd1:    c = 9'd0;
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			c = c + 9'd1;
		end
		return c;
	endfunction

	// Month holding day offset rem within its year
	function automatic logic [3:0] month_of(logic [8:0] rem, logic leap);
		logic [3:0] m;
		m = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (rem >= cum_days(4'(k), leap)) begin
				m = m + 4'd1;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/gregorian_day_number_converter.sv
`default_nettype none

// Gregorian date / day-number converter, year 0 as epoch and counted leap.
// Request channel (req_valid, req_stall, req): one transfer carries an op and
// its operands. Op 0 gives the day number of date A (0000-01-01 is 1), op 1
// turns serial_in into a date (0 is 0000-01-01), op 2 gives B minus A.
// Result channel (rsp_valid, rsp_stall, rsp): one transfer per request, with
// bad_input set and every other field zero for a bad month, a year above
// MAX_YEAR, a day number past the last day of MAX_YEAR, or op 3.
// Each op runs its own program from the control store; op 1 repeats a year
// probe until the day number lies inside the probed year, and a bad request
// jumps straight to the last step. Each probe is paced by the two-stage
// year-days unit shared by all ops, driven from the control store.
// One request is worked on at a time; the next is taken once the current
// result sits in the output register. A stalled result holds its value; the
// program waits at its last step until the output register is free.
// Reset clears the sequencer and the result valid flag.
module gregorian_day_number_converter #(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire gdn_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output gdn_pkg::rsp_t      rsp
);

	gdn_pkg::ctrl_t ctrl;
	gdn_pkg::stat_t stat;
	logic           accept;
	logic           out_load;

	gdn_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctrl      (ctrl),
		.accept    (accept),
		.out_load  (out_load)
	);

	gdn_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.accept   (accept),
		.ctrl     (ctrl),
		.out_load (out_load),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

### hw/rtl/gdn_year_days.sv
`default_nettype none

// Days in all years before the given one, two register stages deep
module gdn_year_days #(
	parameter int YW = 14,
	parameter int SW = 22
) (
	input  wire logic          clk,
	input  wire logic [YW-1:0] year,
	output logic      [SW-1:0] days
);

	localparam int EW = YW + 8;
	localparam int PW = EW + gdn_pkg::RecipW;

	logic [EW-1:0] ext;
	logic [EW-1:0] q4;
	logic [EW-1:0] x25;
	logic [YW-1:0] y_s1;
	logic [YW-1:0] c4_s1;
	logic [PW-1:0] prod_s1;
	logic [EW-1:0] c100;
	logic [EW-1:0] c400;
	logic [SW-1:0] days_s2;

	// Quarter counts, and the hundreds count by reciprocal of 25
	assign ext = EW'(year);
	assign q4  = (ext + EW'(3)) >> 2;
	assign x25 = (ext + EW'(gdn_pkg::Centennial - 1)) >> 2;

	always_ff @(posedge clk) begin
		y_s1    <= year;
		c4_s1   <= YW'(q4);
		prod_s1 <= PW'(x25) * PW'(gdn_pkg::Recip25);
	end

	// Ceilings of y/100 and y/400
	assign c100 = EW'(prod_s1 >> gdn_pkg::RecipShift);
	assign c400 = (c100 + EW'(3)) >> 2;

	always_ff @(posedge clk) begin
		days_s2 <= SW'(y_s1) * SW'(gdn_pkg::DaysPerYear) + SW'(c4_s1)
			- SW'(c100) + SW'(c400);
	end

	assign days = days_s2;

endmodule

`default_nettype wire

### hw/rtl/gdn_datapath.sv
`default_nettype none

module gdn_datapath #(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire gdn_pkg::req_t   req,
	input  wire logic            accept,
	input  wire gdn_pkg::ctrl_t  ctrl,
	input  wire logic            out_load,
	output gdn_pkg::stat_t       stat,
	output gdn_pkg::rsp_t        rsp
);

	localparam int YW = $clog2(MAX_YEAR + 2);
	localparam int SW = $clog2(366 * (MAX_YEAR + 3));
	localparam int AW = SW + 1;
	localparam int MW = SW + gdn_pkg::EstW;
	localparam int LastSerial = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
		- (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;

	gdn_pkg::req_t     req_q;
	logic              bad_q;
	logic [SW-1:0]     sn_q;
	logic [YW-1:0]     yr_q;
	logic [SW-1:0]     lo_q;
	logic [SW-1:0]     hi_q;
	logic [SW-1:0]     num_q;
	logic signed [AW-1:0] acc_q;
	logic [8:0]        rem_q;
	logic [3:0]        mon_q;
	logic [4:0]        day_q;
	gdn_pkg::rsp_t     rsp_q;

	logic              ok_a;
	logic              ok_b;
	logic              sn_ok;
	logic              bad_in;
	logic [YW-1:0]     unit_year;
	logic [SW-1:0]     unit_days;
	logic [MW-1:0]     est_prod;
	logic [MW-1:0]     est_raw;
	logic [YW-1:0]     est;
	logic              lo_gt;
	logic              hi_le;
	logic              leap;
	logic [3:0]        sel_month;
	logic [4:0]        sel_day;
	logic [8:0]        day_off;
	gdn_pkg::rsp_t     rsp_d;

	// Range checks on the incoming request
	assign ok_a  = req.month_a >= 4'd1 && req.month_a <= 4'd12
		&& 32'(req.year_a) <= 32'(MAX_YEAR);
	assign ok_b  = req.month_b >= 4'd1 && req.month_b <= 4'd12
		&& 32'(req.year_b) <= 32'(MAX_YEAR);
	assign sn_ok = 32'(req.serial_in) < 32'(LastSerial);

	always_comb begin
		case (req.op)
			gdn_pkg::OpToSerial: bad_in = !ok_a;
			gdn_pkg::OpToDate:   bad_in = !sn_ok;
			gdn_pkg::OpDiff:     bad_in = !(ok_a && ok_b);
			default:             bad_in = 1'b1;
		endcase
	end

	// Hold the request for the length of the program
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			bad_q <= bad_in;
			sn_q  <= SW'(req.serial_in);
		end
	end

	// Shared year-days unit
	assign unit_year = yr_q + YW'(ctrl.plus1);

	gdn_year_days #(
		.YW (YW),
		.SW (SW)
	) u_year_days (
		.clk  (clk),
		.year (unit_year),
		.days (unit_days)
	);

	// Starting year for the search, clamped to the last legal year
	assign est_prod = MW'(sn_q) * MW'(gdn_pkg::EstMul);
	assign est_raw  = est_prod >> gdn_pkg::EstShift;
	assign est      = (est_raw > MW'(MAX_YEAR)) ? YW'(MAX_YEAR) : YW'(est_raw);

	assign lo_gt = lo_q > sn_q;
	assign hi_le = hi_q <= sn_q;
	assign leap  = (hi_q - lo_q) == SW'(gdn_pkg::DaysLeapYear);

	// Year register: load, or step towards the year holding the day number
	always_ff @(posedge clk) begin
		case (ctrl.yr_src)
			gdn_pkg::YR_LOAD_A:   yr_q <= YW'(req_q.year_a);
			gdn_pkg::YR_LOAD_B:   yr_q <= YW'(req_q.year_b);
			gdn_pkg::YR_LOAD_EST: yr_q <= est;
			gdn_pkg::YR_SEARCH: begin
				if (lo_gt) begin
					yr_q <= yr_q - YW'(1);
				end else if (hi_le) begin
					yr_q <= yr_q + YW'(1);
				end
			end
			default: ;
		endcase
	end

	// Capture year boundaries from the unit
	always_ff @(posedge clk) begin
		if (ctrl.cap_lo) begin
			lo_q <= unit_days;
		end
		if (ctrl.cap_hi) begin
			hi_q <= unit_days;
		end
	end

	// Day number of the selected date
	assign sel_month = ctrl.use_b ? req_q.month_b : req_q.month_a;
	assign sel_day   = ctrl.use_b ? req_q.day_b : req_q.day_a;

	always_ff @(posedge clk) begin
		if (ctrl.num_en) begin
			num_q <= lo_q + SW'(gdn_pkg::cum_days(sel_month, leap)) + SW'(sel_day);
		end
	end

	// Accumulate the signed result
	always_ff @(posedge clk) begin
		case (ctrl.acc_op)
			gdn_pkg::ACC_LOAD: acc_q <= signed'({1'b0, num_q});
			gdn_pkg::ACC_SUB:  acc_q <= acc_q - signed'({1'b0, num_q});
			default: ;
		endcase
	end

	// Split the day offset into month and day
	assign day_off = rem_q - gdn_pkg::cum_days(mon_q, leap) + 9'd1;

	always_ff @(posedge clk) begin
		if (ctrl.rem_en) begin
			rem_q <= 9'(sn_q - lo_q);
		end
		if (ctrl.mon_en) begin
			mon_q <= gdn_pkg::month_of(rem_q, leap);
		end
		if (ctrl.day_en) begin
			day_q <= 5'(day_off);
		end
	end

	// Assemble the result; unused fields stay zero
	always_comb begin
		rsp_d = '0;
		if (bad_q) begin
			rsp_d.bad_input = 1'b1;
		end else if (req_q.op == gdn_pkg::OpToDate) begin
			rsp_d.day_out   = day_q;
			rsp_d.month_out = mon_q;
			rsp_d.year_out  = 14'(yr_q);
		end else begin
			rsp_d.serial_out = 23'(acc_q);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	assign stat.bad  = bad_q;
	assign stat.op1  = req_q.op == gdn_pkg::OpToDate;
	assign stat.op2  = req_q.op == gdn_pkg::OpDiff;
	assign stat.move = lo_gt || hi_le;

	// A valid year spans 365 or 366 days
	a_year_len: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.num_en |-> (hi_q - lo_q == SW'(gdn_pkg::DaysPerYear))
			|| (hi_q - lo_q == SW'(gdn_pkg::DaysLeapYear)))
		else $error("year length out of range");

	// Day offset stays inside the found year
	a_rem_in_year: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mon_en |-> rem_q < (leap ? 9'd366 : 9'd365))
		else $error("day offset beyond year end");

	// Search never leaves the legal years
	a_search_year: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.yr_src == gdn_pkg::YR_SEARCH |-> yr_q <= YW'(MAX_YEAR))
		else $error("search year above limit");

endmodule

`default_nettype wire

### hw/rtl/gdn_sequencer.sv
`default_nettype none

module gdn_sequencer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	input  wire gdn_pkg::stat_t stat,
	output gdn_pkg::ctrl_t      ctrl,
	output logic                accept,
	output logic                out_load
);

	logic            busy_q;
	gdn_pkg::step_t  step_q;
	logic            out_valid_q;
	gdn_pkg::ctrl_t  word;
	logic            jump;
	logic            out_free;

	// Fetch the control word; quiet when idle
	assign word = gdn_pkg::rom_word(step_q);
	assign ctrl = busy_q ? word : '0;

	always_comb begin
		case (word.cond)
			gdn_pkg::COND_NEXT:   jump = 1'b0;
			gdn_pkg::COND_ALWAYS: jump = 1'b1;
			gdn_pkg::COND_BAD:    jump = stat.bad;
			gdn_pkg::COND_OP1:    jump = stat.op1;
			gdn_pkg::COND_OP2:    jump = stat.op2;
			gdn_pkg::COND_MOVE:   jump = stat.move;
			default:              jump = 1'b0;
		endcase
	end

	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign out_load  = busy_q && word.done && out_free;
	assign rsp_valid = out_valid_q;

	// Advance the step counter; hold at the final step until the result slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (word.done) begin
					if (out_free) begin
						busy_q <= 1'b0;
					end
				end else if (jump) begin
					step_q <= word.target;
				end else begin
					step_q <= step_q + gdn_pkg::step_t'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= gdn_pkg::StepDone)
		else $error("step counter past program end");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !busy_q && rsp_valid)
		else $error("result load did not end the item");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> busy_q && step_q == '0)
		else $error("program did not start at step zero");

endmodule

`default_nettype wire
